FILE: rtl/dasu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dasu_pkg: shared definitions of the decimal add/subtract unit
// Operation codes, state encoding, sizing constants and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dasu_pkg;

   // Sizing
   localparam int MAX_DIGITS = 40;
   // Counts and result positions run from 0 to MAX_DIGITS
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   // Operand store address
   localparam int OP_ADDR_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DIGIT_W    = 4;
   localparam int OP_W       = 3;

   // Decimal constants
   localparam logic [DIGIT_W:0]   DEC_BASE  = 5'd10;
   localparam logic [DIGIT_W-1:0] DEC_NINE  = 4'd9;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_FIRST  = 3'd0,
      OP_LOAD_SECOND = 3'd1,
      OP_SUM         = 3'd2,
      OP_DIFF        = 3'd3,
      OP_CLEAR       = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_FINISH,
      ST_EREAD,
      ST_EOUT
   } state_type;

   // Magnitude comparison of first against second
   typedef enum logic [1:0] {
      CMP_EQ,
      CMP_GT,
      CMP_LT
   } cmp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_first;
      logic load_second;
      logic clear;
      logic begin_op;
      logic is_diff;
      logic read_ops;
      logic calc;
      logic finish;
      logic emit_read;
      logic emit_step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pos_done;
      logic emit_last;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/decimal_add_subtract_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_add_subtract_unit: multi-digit decimal adder and subtractor
// Loads two decimal operands digit by digit and streams their sum or signed
// difference most significant digit first with leading zeros suppressed.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Load and clear
// commands leave busy low. A sum or difference keeps busy high from the
// accepting edge until its last digit is out: each operand position goes
// through the registered operand store read and the digit ripple, and
// each emitted digit through the registered result buffer read. Every
// result digit appears for exactly one cycle with rsp_strobe high and is
// not held: the receiver must take it in that cycle. A result buffer read
// lies between two digits and busy falls in the cycle after the digit
// flagged rsp_last_digit.
// ----------------------------------------------------------------------------
module decimal_add_subtract_unit
   import dasu_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire [OP_W-1:0]      req_operation,
   input  wire [DIGIT_W-1:0]   req_digit,
   output logic                rsp_strobe,
   output logic [DIGIT_W-1:0]  rsp_result_digit,
   output logic                rsp_negative,
   output logic                rsp_too_long,
   output logic                rsp_last_digit
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   dasu_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe)
   );

   // Stores and arithmetic
   dasu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .load_digit       (req_digit),
      .status           (status),
      .rsp_result_digit (rsp_result_digit),
      .rsp_negative     (rsp_negative),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_digit   (rsp_last_digit)
   );

   // A transfer out only happens while a command is in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a command");

   // The final digit ends the command
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_digit) |=> !busy)
      else $error("busy held after final digit");

   // Digits are spaced by the buffer read cycle
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_digit) |=> (!rsp_strobe && busy))
      else $error("result digits too close or command dropped");

   // Loads and clear leave the unit free for the next command
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_LOAD_FIRST ||
       req_operation == OP_LOAD_SECOND || req_operation == OP_CLEAR)) |=> !busy)
      else $error("load or clear left the unit busy");

   // Every emitted digit stays a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_result_digit <= DEC_NINE))
      else $error("result digit above nine");

endmodule
`default_nettype wire

FILE: rtl/dasu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dasu_datapath: operand stores, digit arithmetic and result buffers
// Holds both operands, ripples the sum or both differences one digit per
// pass and replays the chosen result buffer most significant digit first.
// ----------------------------------------------------------------------------
module dasu_datapath
   import dasu_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  cmd_type                 cmd,
   input  wire [DIGIT_W-1:0]       load_digit,
   output status_type              status,
   output logic [DIGIT_W-1:0]      rsp_result_digit,
   output logic                    rsp_negative,
   output logic                    rsp_too_long,
   output logic                    rsp_last_digit
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

   // Stores
   logic [DIGIT_W-1:0] first_mem  [MAX_DIGITS];
   logic [DIGIT_W-1:0] second_mem [MAX_DIGITS];
   logic [DIGIT_W-1:0] buf_a_mem  [MAX_DIGITS + 1];
   logic [DIGIT_W-1:0] buf_b_mem  [MAX_DIGITS + 1];

   // Registers
   logic [CNT_W-1:0]   first_len_ff, first_len_in;
   logic [CNT_W-1:0]   second_len_ff, second_len_in;
   logic               overflow_ff, overflow_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               carry_ff, carry_in;
   logic               borrow_b_ff, borrow_b_in;
   logic [CNT_W-1:0]   top_a_ff, top_a_in;
   logic [CNT_W-1:0]   top_b_ff, top_b_in;
   cmp_type            cmp_ff, cmp_in;
   logic               is_diff_ff, is_diff_in;
   logic [CNT_W-1:0]   emit_idx_ff, emit_idx_in;
   logic               sel_b_ff, sel_b_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;
   logic               in_a_ff, in_b_ff;
   logic [DIGIT_W-1:0] first_rd_ff, second_rd_ff;
   logic [DIGIT_W-1:0] buf_a_rd_ff, buf_b_rd_ff;

   // Combinational
   logic [CNT_W-1:0]   width;
   logic [DIGIT_W-1:0] clamped;
   logic [CNT_W-1:0]   first_addr, second_addr;
   logic [DIGIT_W-1:0] op_a, op_b;
   logic [DIGIT_W:0]   sum5, sub_a, sub_b, diff_a5, diff_b5;
   logic               sum_wrap, a_lt, b_lt;
   logic [DIGIT_W-1:0] digit_a, digit_b;
   logic               buf_a_we;
   logic [DIGIT_W-1:0] buf_a_wd;
   logic [CNT_W-1:0]   add_top;

   assign width   = (first_len_ff > second_len_ff) ? first_len_ff : second_len_ff;
   assign clamped = (load_digit > DEC_NINE) ? DEC_NINE : load_digit;

   // Operand digit at position pos from the least significant end
   assign first_addr  = first_len_ff - pos_ff - CNT_W'(1);
   assign second_addr = second_len_ff - pos_ff - CNT_W'(1);

   assign status.pos_done  = (pos_ff == width);
   assign status.emit_last = (emit_idx_ff == '0);

   // One digit of sum and of both differences
   always_comb begin
      op_a     = in_a_ff ? first_rd_ff : '0;
      op_b     = in_b_ff ? second_rd_ff : '0;
      sum5     = {1'b0, op_a} + {1'b0, op_b} + {{DIGIT_W{1'b0}}, carry_ff};
      sum_wrap = (sum5 >= DEC_BASE);
      sub_a    = {1'b0, op_b} + {{DIGIT_W{1'b0}}, carry_ff};
      sub_b    = {1'b0, op_a} + {{DIGIT_W{1'b0}}, borrow_b_ff};
      a_lt     = ({1'b0, op_a} < sub_a);
      b_lt     = ({1'b0, op_b} < sub_b);
      diff_a5  = a_lt ? ({1'b0, op_a} + DEC_BASE - sub_a) : ({1'b0, op_a} - sub_a);
      diff_b5  = b_lt ? ({1'b0, op_b} + DEC_BASE - sub_b) : ({1'b0, op_b} - sub_b);
      digit_b  = diff_b5[DIGIT_W-1:0];
      if (is_diff_ff) begin
         digit_a = diff_a5[DIGIT_W-1:0];
      end else if (sum_wrap) begin
         digit_a = sum5[DIGIT_W-1:0] - DEC_BASE[DIGIT_W-1:0];
      end else begin
         digit_a = sum5[DIGIT_W-1:0];
      end
   end

   assign add_top  = carry_ff ? pos_ff : top_a_ff;
   assign buf_a_we = cmd.calc | (cmd.finish & ~is_diff_ff);
   assign buf_a_wd = cmd.calc ? digit_a : {{(DIGIT_W-1){1'b0}}, carry_ff};

   // Next values of the control registers
   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      overflow_in   = overflow_ff;
      pos_in        = pos_ff;
      carry_in      = carry_ff;
      borrow_b_in   = borrow_b_ff;
      top_a_in      = top_a_ff;
      top_b_in      = top_b_ff;
      cmp_in        = cmp_ff;
      is_diff_in    = is_diff_ff;
      emit_idx_in   = emit_idx_ff;
      sel_b_in      = sel_b_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;

      // loads drop when full and flag it
      if (cmd.load_first) begin
         if (first_len_ff == MAX_CNT) overflow_in = 1'b1;
         else                         first_len_in = first_len_ff + CNT_W'(1);
      end
      if (cmd.load_second) begin
         if (second_len_ff == MAX_CNT) overflow_in = 1'b1;
         else                          second_len_in = second_len_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         first_len_in  = '0;
         second_len_in = '0;
         overflow_in   = 1'b0;
      end

      // start a pass
      if (cmd.begin_op) begin
         pos_in      = '0;
         carry_in    = 1'b0;
         borrow_b_in = 1'b0;
         top_a_in    = '0;
         top_b_in    = '0;
         cmp_in      = CMP_EQ;
         is_diff_in  = cmd.is_diff;
      end

      // advance one digit; the more significant difference decides
      if (cmd.calc) begin
         pos_in      = pos_ff + CNT_W'(1);
         carry_in    = is_diff_ff ? a_lt : sum_wrap;
         borrow_b_in = b_lt;
         if (digit_a != '0) top_a_in = pos_ff;
         if (digit_b != '0) top_b_in = pos_ff;
         if (op_a > op_b)      cmp_in = CMP_GT;
         else if (op_a < op_b) cmp_in = CMP_LT;
      end

      // pick the buffer and its top digit
      if (cmd.finish) begin
         if (is_diff_ff) begin
            sel_b_in    = (cmp_ff == CMP_LT);
            neg_in      = (cmp_ff == CMP_LT);
            zero_in     = (cmp_ff == CMP_EQ);
            emit_idx_in = (cmp_ff == CMP_LT) ? top_b_ff : top_a_ff;
         end else begin
            sel_b_in    = 1'b0;
            neg_in      = 1'b0;
            zero_in     = 1'b0;
            top_a_in    = add_top;
            emit_idx_in = add_top;
         end
      end

      if (cmd.emit_step && (emit_idx_ff != '0)) begin
         emit_idx_in = emit_idx_ff - CNT_W'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
         pos_ff        <= '0;
         carry_ff      <= 1'b0;
         borrow_b_ff   <= 1'b0;
         top_a_ff      <= '0;
         top_b_ff      <= '0;
         cmp_ff        <= CMP_EQ;
         is_diff_ff    <= 1'b0;
         emit_idx_ff   <= '0;
         sel_b_ff      <= 1'b0;
         neg_ff        <= 1'b0;
         zero_ff       <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         overflow_ff   <= overflow_in;
         pos_ff        <= pos_in;
         carry_ff      <= carry_in;
         borrow_b_ff   <= borrow_b_in;
         top_a_ff      <= top_a_in;
         top_b_ff      <= top_b_in;
         cmp_ff        <= cmp_in;
         is_diff_ff    <= is_diff_in;
         emit_idx_ff   <= emit_idx_in;
         sel_b_ff      <= sel_b_in;
         neg_ff        <= neg_in;
         zero_ff       <= zero_in;
      end
   end

   // Operand stores: write on load, registered read of one digit per pass
   always_ff @(posedge clock) begin
      if (cmd.load_first && (first_len_ff != MAX_CNT)) begin
         first_mem[first_len_ff[OP_ADDR_W-1:0]] <= clamped;
      end
      if (cmd.load_second && (second_len_ff != MAX_CNT)) begin
         second_mem[second_len_ff[OP_ADDR_W-1:0]] <= clamped;
      end
      if (cmd.read_ops) begin
         first_rd_ff  <= first_mem[first_addr[OP_ADDR_W-1:0]];
         second_rd_ff <= second_mem[second_addr[OP_ADDR_W-1:0]];
         in_a_ff      <= (pos_ff < first_len_ff);
         in_b_ff      <= (pos_ff < second_len_ff);
      end
   end

   // Result buffers: written least significant first, replayed from the top
   always_ff @(posedge clock) begin
      if (buf_a_we) begin
         buf_a_mem[pos_ff] <= buf_a_wd;
      end
      if (cmd.calc) begin
         buf_b_mem[pos_ff] <= digit_b;
      end
      if (cmd.emit_read) begin
         buf_a_rd_ff <= buf_a_mem[emit_idx_ff];
         buf_b_rd_ff <= buf_b_mem[emit_idx_ff];
      end
   end

   // Result fields
   always_comb begin
      if (zero_ff)       rsp_result_digit = '0;
      else if (sel_b_ff) rsp_result_digit = buf_b_rd_ff;
      else               rsp_result_digit = buf_a_rd_ff;
   end

   assign rsp_negative   = neg_ff;
   assign rsp_too_long   = overflow_ff;
   assign rsp_last_digit = (emit_idx_ff == '0);

endmodule
`default_nettype wire

FILE: rtl/dasu_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dasu_controller: sequencing of loads, digit passes and result replay
// Decodes accepted commands and steps the datapath through read, compute,
// finish and emit phases.
// ----------------------------------------------------------------------------
module dasu_controller
   import dasu_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             start,
   input  wire [OP_W-1:0]  req_operation,
   input  status_type      status,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_strobe
);

   state_type state_ff, state_in;
   logic      accept;
   op_type    op;

   assign accept = start & (state_ff == ST_IDLE);
   assign op     = op_type'(req_operation);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && ((op == OP_SUM) || (op == OP_DIFF))) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = status.pos_done ? ST_FINISH : ST_CALC;
         end
         ST_CALC:   state_in = ST_READ;
         ST_FINISH: state_in = ST_EREAD;
         ST_EREAD:  state_in = ST_EOUT;
         ST_EOUT: begin
            state_in = status.emit_last ? ST_IDLE : ST_EREAD;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               unique case (op)
                  OP_LOAD_FIRST:  cmd.load_first  = 1'b1;
                  OP_LOAD_SECOND: cmd.load_second = 1'b1;
                  OP_CLEAR:       cmd.clear       = 1'b1;
                  OP_SUM, OP_DIFF: begin
                     cmd.begin_op = 1'b1;
                     cmd.is_diff  = (op == OP_DIFF);
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (!status.pos_done) cmd.read_ops = 1'b1;
         end
         ST_CALC:   cmd.calc      = 1'b1;
         ST_FINISH: cmd.finish    = 1'b1;
         ST_EREAD:  cmd.emit_read = 1'b1;
         ST_EOUT: begin
            cmd.emit_step = 1'b1;
            rsp_strobe    = 1'b1;
         end
         default: ;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: dv/decimal_add_subtract_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_add_subtract_unit_checker: digit stream predictor and comparator
// Watches command transfers into the unit, keeps its own copy of both decimal
// operands and predicts every emitted sum or difference digit. Each result
// transfer is compared field by field with the oldest predicted digit.
// ----------------------------------------------------------------------------
module decimal_add_subtract_unit_checker
   import dasu_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire                busy,
   input  wire [OP_W-1:0]     req_operation,
   input  wire [DIGIT_W-1:0]  req_digit,
   input  wire                rsp_strobe,
   input  wire [DIGIT_W-1:0]  rsp_result_digit,
   input  wire                rsp_negative,
   input  wire                rsp_too_long,
   input  wire                rsp_last_digit,
   output int                 error_count,
   output int                 digits_pending,
   output int                 digits_checked
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [DIGIT_W-1:0] value;
      logic               negative;
      logic               too_long;
      logic               last_digit;
   } result_digit_type;

   result_digit_type   expected_digits[$];
   logic [DIGIT_W-1:0] first_store  [MAX_DIGITS];
   logic [DIGIT_W-1:0] second_store [MAX_DIGITS];
   logic [DIGIT_W-1:0] result_work  [MAX_DIGITS+1];
   int                 first_len     = 0;
   int                 second_len    = 0;
   logic               dropped_load  = 1'b0;
   int                 fail_total    = 0;
   int                 checked_total = 0;

   // Digit of an operand counted from its least significant end; zero beyond it
   function automatic logic [DIGIT_W-1:0] operand_digit(input logic from_second,
                                                        input int pos);
      if (from_second)
         return (pos < second_len) ? second_store[second_len-1-pos] : '0;
      return (pos < first_len) ? first_store[first_len-1-pos] : '0;
   endfunction

   // Append a digit, clamping values above nine; drop it when the operand is full
   task automatic append_digit(input logic to_second, input logic [DIGIT_W-1:0] raw);
      logic [DIGIT_W-1:0] value;
      value = (raw > DEC_NINE) ? DEC_NINE : raw;
      if (to_second) begin
         if (second_len >= MAX_DIGITS) begin
            dropped_load = 1'b1;
         end else begin
            second_store[second_len] = value;
            second_len++;
         end
      end else begin
         if (first_len >= MAX_DIGITS) begin
            dropped_load = 1'b1;
         end else begin
            first_store[first_len] = value;
            first_len++;
         end
      end
   endtask

   // Queue the work buffer most significant first, leading zeros stripped
   task automatic queue_result(input int n, input logic neg);
      int               keep;
      result_digit_type rec;
      keep = n;
      while (keep > 1 && result_work[keep-1] == '0)
         keep--;
      for (int k = keep; k > 0; k--) begin
         rec.value      = result_work[k-1];
         rec.negative   = neg;
         rec.too_long   = dropped_load;
         rec.last_digit = (k == 1);
         expected_digits.push_back(rec);
      end
   endtask

   function automatic cmp_type compare_magnitudes(input int width);
      logic [DIGIT_W-1:0] a;
      logic [DIGIT_W-1:0] b;
      for (int p = width - 1; p >= 0; p--) begin
         a = operand_digit(1'b0, p);
         b = operand_digit(1'b1, p);
         if (a != b)
            return (a > b) ? CMP_GT : CMP_LT;
      end
      return CMP_EQ;
   endfunction

   // Ripple the carry from the least significant digit, keep the carry out
   task automatic predict_sum();
      int   width;
      int   total;
      logic carry;
      width = (first_len > second_len) ? first_len : second_len;
      carry = 1'b0;
      for (int p = 0; p < width; p++) begin
         total = operand_digit(1'b0, p) + operand_digit(1'b1, p) + carry;
         carry = (total >= DEC_BASE);
         result_work[p] = carry ? DIGIT_W'(total - DEC_BASE) : DIGIT_W'(total);
      end
      result_work[width] = DIGIT_W'(carry);
      queue_result(width + 1, 1'b0);
   endtask

   // Subtract the smaller magnitude from the larger with a borrow ripple
   task automatic predict_difference();
      int      width;
      int      minuend;
      int      subtrahend;
      logic    borrow;
      logic    second_larger;
      cmp_type relation;
      width    = (first_len > second_len) ? first_len : second_len;
      relation = compare_magnitudes(width);
      if (relation == CMP_EQ) begin
         result_work[0] = '0;
         queue_result(1, 1'b0);
      end else begin
         second_larger = (relation == CMP_LT);
         borrow        = 1'b0;
         for (int p = 0; p < width; p++) begin
            minuend    = operand_digit(second_larger, p);
            subtrahend = operand_digit(!second_larger, p) + borrow;
            if (minuend < subtrahend) begin
               result_work[p] = DIGIT_W'(minuend + DEC_BASE - subtrahend);
               borrow         = 1'b1;
            end else begin
               result_work[p] = DIGIT_W'(minuend - subtrahend);
               borrow         = 1'b0;
            end
         end
         queue_result(width, second_larger);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      result_digit_type want;
      result_digit_type got;
      if (reset) begin
         first_len    = 0;
         second_len   = 0;
         dropped_load = 1'b0;
         expected_digits.delete();
      end else begin
         // Check a result transfer against the oldest predicted digit
         if (rsp_strobe) begin
            got.value      = rsp_result_digit;
            got.negative   = rsp_negative;
            got.too_long   = rsp_too_long;
            got.last_digit = rsp_last_digit;
            if (expected_digits.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("%0t: unexpected digit %0d neg %b long %b last %b", $time,
                           got.value, got.negative, got.too_long, got.last_digit);
            end else begin
               want = expected_digits.pop_front();
               checked_total++;
               if (got !== want) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT)
                     $display({"%0t: digit exp %0d/neg %b/long %b/last %b,",
                               " got %0d/neg %b/long %b/last %b"}, $time,
                              want.value, want.negative, want.too_long, want.last_digit,
                              got.value, got.negative, got.too_long, got.last_digit);
               end
            end
         end
         // Update the operands or predict the stream on a command transfer
         if (start && !busy) begin
            case (req_operation)
               OP_LOAD_FIRST:  append_digit(1'b0, req_digit);
               OP_LOAD_SECOND: append_digit(1'b1, req_digit);
               OP_SUM:         predict_sum();
               OP_DIFF:        predict_difference();
               OP_CLEAR: begin
                  first_len    = 0;
                  second_len   = 0;
                  dropped_load = 1'b0;
               end
               default: ;
            endcase
         end
      end
      error_count    <= fail_total;
      digits_pending <= expected_digits.size();
      digits_checked <= checked_total;
   end

endmodule

FILE: dv/decimal_add_subtract_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_add_subtract_unit_tb: top level of the decimal unit testbench
// Drives load, clear, sum, difference and spare commands with random gaps: a short
// directed opening, then rounds of operand pairs with random digits, carry
// and borrow chains, equal values with leading zeros and full operands.
// The checker beside the unit predicts and compares every result digit.
// ----------------------------------------------------------------------------
module decimal_add_subtract_unit_tb;
   import dasu_pkg::*;

   localparam int              ITEM_TARGET    = 310;
   localparam int              CYCLE_LIMIT    = 400000;
   localparam int              SETTLE_CYCLES  = 2*MAX_DIGITS + 2*(MAX_DIGITS+1) + 16;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   typedef enum int {
      MIX_PLAIN,
      MIX_CHAIN,
      MIX_EQUAL,
      MIX_NOISE
   } round_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic [OP_W-1:0]    req_operation;
   logic [DIGIT_W-1:0] req_digit;
   wire                busy;
   wire                rsp_strobe;
   wire [DIGIT_W-1:0]  rsp_result_digit;
   wire                rsp_negative;
   wire                rsp_too_long;
   wire                rsp_last_digit;

   int   error_count;
   int   digits_pending;
   int   digits_checked;
   int   cycle_count    = 0;
   int   transfer_count = 0;
   int   load_count     = 0;
   int   drop_count     = 0;
   int   sum_count      = 0;
   int   diff_count     = 0;
   int   clear_count    = 0;
   int   spare_count    = 0;
   int   first_fill     = 0;
   int   second_fill    = 0;
   logic idle_on        = 1'b0;

   decimal_add_subtract_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_digit        (req_digit),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_digit (rsp_result_digit),
      .rsp_negative     (rsp_negative),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_digit   (rsp_last_digit)
   );

   decimal_add_subtract_unit_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_digit        (req_digit),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_digit (rsp_result_digit),
      .rsp_negative     (rsp_negative),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_digit   (rsp_last_digit),
      .error_count      (error_count),
      .digits_pending   (digits_pending),
      .digits_checked   (digits_checked)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("decimal_add_subtract_unit: mismatch");
         $finish;
      end
   end

   function automatic logic [DIGIT_W-1:0] any_digit();
      return DIGIT_W'($urandom_range(0, 15));
   endfunction

   // Mostly short operands, now and then one around the store size
   function automatic int draw_length();
      if ($urandom_range(0, 11) == 0)
         return $urandom_range(MAX_DIGITS - 2, MAX_DIGITS + 2);
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [DIGIT_W-1:0] draw_digit(input round_type kind);
      if (kind == MIX_CHAIN)
         return $urandom_range(0, 1) ? DEC_NINE : '0;
      if (kind == MIX_PLAIN && $urandom_range(0, 4) == 0)
         return DIGIT_W'($urandom_range(10, 15));
      return DIGIT_W'($urandom_range(0, 9));
   endfunction

   // Hold start after an optional gap until the command transfer completes
   task automatic send_command(input logic [OP_W-1:0] op, input logic [DIGIT_W-1:0] dig);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_digit     <= dig;
      do begin
         @(posedge clock);
      end while (busy);
      case (op)
         OP_LOAD_FIRST: begin
            load_count++;
            if (first_fill >= MAX_DIGITS) drop_count++;
            else first_fill++;
         end
         OP_LOAD_SECOND: begin
            load_count++;
            if (second_fill >= MAX_DIGITS) drop_count++;
            else second_fill++;
         end
         OP_SUM:  sum_count++;
         OP_DIFF: diff_count++;
         OP_CLEAR: begin
            clear_count++;
            first_fill  = 0;
            second_fill = 0;
         end
         default: spare_count++;
      endcase
      if (op < OP_SPARE_FIRST)
         transfer_count++;
   endtask

   // Drop start and hold off until every predicted digit has arrived
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (digits_pending != 0)
         @(posedge clock);
   endtask

   // One operand pair followed by a few sums and differences
   task automatic random_round(input int round_no);
      round_type          kind;
      int                 pick;
      int                 n_first;
      int                 n_second;
      logic [OP_W-1:0]    op_pick;
      logic [DIGIT_W-1:0] first_seq[$];
      logic [DIGIT_W-1:0] second_seq[$];
      pick    = $urandom_range(0, 9);
      kind    = (pick < 5) ? MIX_PLAIN : (pick < 7) ? MIX_CHAIN :
                (pick < 9) ? MIX_EQUAL : MIX_NOISE;
      idle_on = ($urandom_range(0, 3) != 0);
      // Noise: any code, any digit
      if (kind == MIX_NOISE) begin
         repeat ($urandom_range(1, 6)) begin
            op_pick = OP_W'($urandom_range(0, 7));
            send_command(op_pick, any_digit());
         end
         return;
      end
      n_first = (round_no == 2) ? MAX_DIGITS + 1 : draw_length();
      for (int i = 0; i < n_first; i++)
         first_seq.push_back(draw_digit(kind));
      // Equal values: same digits behind a few leading zeros
      if (kind == MIX_EQUAL) begin
         repeat ($urandom_range(0, 2))
            second_seq.push_back('0);
         foreach (first_seq[i])
            second_seq.push_back(first_seq[i]);
      end else begin
         n_second = draw_length();
         for (int i = 0; i < n_second; i++)
            second_seq.push_back(draw_digit(kind));
      end
      if (kind == MIX_EQUAL || $urandom_range(0, 4) != 0)
         send_command(OP_CLEAR, any_digit());
      // Interleave the loads of both operands
      while (first_seq.size() + second_seq.size() > 0) begin
         if (second_seq.size() == 0 || (first_seq.size() != 0 && $urandom_range(0, 1)))
            send_command(OP_LOAD_FIRST, first_seq.pop_front());
         else
            send_command(OP_LOAD_SECOND, second_seq.pop_front());
      end
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 7) == 0) begin
            op_pick = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            send_command(op_pick, any_digit());
         end
         send_command($urandom_range(0, 1) ? OP_SUM : OP_DIFF, any_digit());
      end
   endtask

   initial begin : stimulus
      int round_no;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_CLEAR;
      req_digit     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty operands, clamped digits, carry out, both signs
      idle_on = 1'b1;
      send_command(OP_SUM, 4'hF);
      send_command(OP_DIFF, 4'h0);
      send_command(OP_LOAD_FIRST, 4'd9);
      send_command(OP_LOAD_FIRST, 4'hF);
      send_command(OP_LOAD_SECOND, 4'd0);
      send_command(OP_LOAD_SECOND, 4'd1);
      send_command(OP_SUM, 4'hA);
      send_command(OP_DIFF, 4'h5);
      send_command(OP_LOAD_SECOND, 4'd0);
      send_command(OP_LOAD_SECOND, 4'd5);
      send_command(OP_DIFF, 4'hC);
      // Spare codes must leave the unit untouched
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
         send_command(OP_W'(c), any_digit());
      send_command(OP_SUM, 4'h3);
      // Equal magnitudes with a leading zero on one side
      send_command(OP_CLEAR, 4'h6);
      send_command(OP_LOAD_FIRST, 4'd0);
      send_command(OP_LOAD_FIRST, 4'd7);
      send_command(OP_LOAD_SECOND, 4'd7);
      send_command(OP_DIFF, 4'h8);
      send_command(OP_SUM, 4'h2);
      drain_results();

      // Random rounds
      round_no = 0;
      while (transfer_count < ITEM_TARGET) begin
         random_round(round_no);
         round_no++;
      end
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d transfers: %0d loads (%0d dropped on a full operand), %0d sums,",
               transfer_count, load_count, drop_count, sum_count);
      $display("  %0d differences, %0d clears, %0d spare codes; %0d result digits checked",
               diff_count, clear_count, spare_count, digits_checked);
      if (error_count == 0)
         $display("decimal_add_subtract_unit: match");
      else
         $display("decimal_add_subtract_unit: mismatch");
      $finish;
   end

endmodule
